### src/nnfr_pkg.sv
// ----------------------------------------------------------------------------
// nnfr_pkg
// Shared types, constants and helpers for the nearest-neighbor forward resize.
// ----------------------------------------------------------------------------
package nnfr_pkg;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int RATIO_W = 29;
  localparam int PIX_W   = 32;
  localparam int REP_W   = 4;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = COORD_W + RATIO_W;

  localparam logic [DIM_W-1:0]   MAX_DIM    = 13'd4096;
  localparam logic [REP_W-1:0]   MAX_REPEAT = 4'd8;
  localparam logic [RATIO_W-1:0] ONE_Q16    = 29'd65536;

  localparam logic [IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] CFG_X_RATIO    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_Y_RATIO    = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0]   src_width;
    logic [DIM_W-1:0]   src_height;
    logic [DIM_W-1:0]   dst_width;
    logic [DIM_W-1:0]   dst_height;
    logic [RATIO_W-1:0] x_ratio_q16;
    logic [RATIO_W-1:0] y_ratio_q16;
  } nnfr_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [REP_W-1:0]   cols;
    logic [REP_W-1:0]   rows;
  } nnfr_job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

### src/nearest_neighbor_forward_resize_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_forward_resize_top
// Nearest-neighbor forward resize: maps each source pixel to its block of
// destination writes, row by row, with the final write of a pixel marked.
//
//   Channel  Handshake                 Payload
//   cfg      cfg_write_en              cfg_index, cfg_data
//   in       in_valid / in_stall       in_pixel
//   out      out_valid / out_stall     dst_x, dst_y, out_pixel, last
//
// The front end accepts a pixel, multiplies its position and classifies it,
// handing any job that lands in the image to a two-entry queue before it
// takes the next pixel. The write sequencer gives one write per cycle while
// the output is not stalled, and loads a new job only once the last is done.
// Synchronous reset clears the scan position, the queue and the output beat,
// and loads the size registers with 1 and the ratios with 1.0.
// A stalled output holds its beat; the queue lets the front end keep working.
// ----------------------------------------------------------------------------
module nearest_neighbor_forward_resize_top
  import nnfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [RATIO_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] dst_x,
  output logic [COORD_W-1:0] dst_y,
  output logic [PIX_W-1:0]   out_pixel,
  output logic               last
);

  nnfr_cfg_t cfg;
  logic      push;
  nnfr_job_t push_job;
  logic      full;
  logic      pop;
  nnfr_job_t pop_job;
  logic      empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width   <= 13'd1;
      cfg.src_height  <= 13'd1;
      cfg.dst_width   <= 13'd1;
      cfg.dst_height  <= 13'd1;
      cfg.x_ratio_q16 <= ONE_Q16;
      cfg.y_ratio_q16 <= ONE_Q16;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  cfg.src_width   <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT: cfg.src_height  <= cfg_data[DIM_W-1:0];
        CFG_DST_WIDTH:  cfg.dst_width   <= cfg_data[DIM_W-1:0];
        CFG_DST_HEIGHT: cfg.dst_height  <= cfg_data[DIM_W-1:0];
        CFG_X_RATIO:    cfg.x_ratio_q16 <= cfg_data;
        CFG_Y_RATIO:    cfg.y_ratio_q16 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  nnfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  nnfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  nnfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_job   (pop_job),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dst_x     (dst_x),
    .dst_y     (dst_y),
    .out_pixel (out_pixel),
    .last      (last)
  );

  // An accepted pixel keeps the input side stalled while it is scaled.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while the front end was busy");

  // Every write lands inside the destination image.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (({1'b0, dst_x} < dim_clamp(cfg.dst_width)) &&
                   ({1'b0, dst_y} < dim_clamp(cfg.dst_height))))
    else $error("write outside the destination image");

  // The write sequencer only takes a job when the queue holds one.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job taken from an empty queue");

endmodule

### src/nnfr_front.sv
// ----------------------------------------------------------------------------
// nnfr_front
// Accepts source pixels, tracks the scan position, scales the position and
// turns each pixel that lands in the destination into a job of row and column repeats for the back end.
// ----------------------------------------------------------------------------
module nnfr_front
  import nnfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  nnfr_cfg_t          cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               push,
  output nnfr_job_t          push_job,
  input  logic               full
);

  front_state_t        state;
  front_state_t        state_next;
  logic [COORD_W-1:0]  scan_col;
  logic [COORD_W-1:0]  scan_row;
  logic [COORD_W-1:0]  col_q;
  logic [COORD_W-1:0]  row_q;
  logic [PIX_W-1:0]    pixel;
  logic [PROD_W-1:0]   prod_x;
  logic [PROD_W-1:0]   prod_y;

  logic                accept;
  logic [DIM_W-1:0]    col_inc;
  logic [DIM_W-1:0]    row_inc;
  logic [DIM_W-1:0]    sw;
  logic [DIM_W-1:0]    sh;
  logic [DIM_W-1:0]    dw;
  logic [DIM_W-1:0]    dh;
  logic [PROD_W-17:0]  base_x;
  logic [PROD_W-17:0]  base_y;
  logic                hit;
  logic [DIM_W-1:0]    span_x;
  logic [DIM_W-1:0]    span_y;
  logic [REP_W-1:0]    rep_x;
  logic [REP_W-1:0]    rep_y;

  function automatic logic [REP_W-1:0] repeat_count(input logic [RATIO_W-1:0] r);
    logic [RATIO_W-17:0] whole;
    whole = r[RATIO_W-1:16];
    if (r <= ONE_Q16) begin
      return 4'd1;
    end
    if (whole >= 13'(MAX_REPEAT - 4'd1)) begin
      return MAX_REPEAT;
    end
    return REP_W'(whole) + 4'd1;
  endfunction

  assign accept  = in_valid && !in_stall;
  assign sw      = dim_clamp(cfg.src_width);
  assign sh      = dim_clamp(cfg.src_height);
  assign dw      = dim_clamp(cfg.dst_width);
  assign dh      = dim_clamp(cfg.dst_height);
  assign col_inc = {1'b0, scan_col} + 13'd1;
  assign row_inc = {1'b0, scan_row} + 13'd1;

  assign base_x = prod_x[PROD_W-1:16];
  assign base_y = prod_y[PROD_W-1:16];
  assign hit    = (base_x < 25'(dw)) && (base_y < 25'(dh));
  assign span_x = dw - base_x[DIM_W-1:0];
  assign span_y = dh - base_y[DIM_W-1:0];
  assign rep_x  = repeat_count(cfg.x_ratio_q16);
  assign rep_y  = repeat_count(cfg.y_ratio_q16);

  always_comb begin
    push_job.pixel  = pixel;
    push_job.base_x = base_x[COORD_W-1:0];
    push_job.base_y = base_y[COORD_W-1:0];
    push_job.cols   = (13'(rep_x) <= span_x) ? rep_x : span_x[REP_W-1:0];
    push_job.rows   = (13'(rep_y) <= span_y) ? rep_y : span_y[REP_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept) begin
          state_next = FR_MUL;
        end
      end
      FR_MUL: begin
        state_next = FR_PUSH;
      end
      FR_PUSH: begin
        if (!hit || !full) begin
          state_next = FR_IDLE;
        end
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    push     = 1'b0;
    unique case (state)
      FR_IDLE: begin
        in_stall = 1'b0;
      end
      FR_MUL: begin
        in_stall = 1'b1;
      end
      FR_PUSH: begin
        push = hit && !full;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FR_IDLE;
      scan_col <= '0;
      scan_row <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (col_inc >= sw) begin
          scan_col <= '0;
          scan_row <= (row_inc >= sh) ? '0 : row_inc[COORD_W-1:0];
        end else begin
          scan_col <= col_inc[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel <= in_pixel;
      col_q <= scan_col;
      row_q <= scan_row;
    end
    if (state == FR_MUL) begin
      prod_x <= PROD_W'(col_q) * PROD_W'(cfg.x_ratio_q16);
      prod_y <= PROD_W'(row_q) * PROD_W'(cfg.y_ratio_q16);
    end
  end

endmodule

### src/nnfr_queue.sv
// ----------------------------------------------------------------------------
// nnfr_queue
// Two-entry job queue that decouples the front end from the write sequencer.
// ----------------------------------------------------------------------------
module nnfr_queue
  import nnfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  nnfr_job_t push_job,
  output logic      full,
  input  logic      pop,
  output nnfr_job_t pop_job,
  output logic      empty
);

  nnfr_job_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### src/nnfr_back.sv
// ----------------------------------------------------------------------------
// nnfr_back
// Write sequencer: walks the rows and columns of one job and emits one
// destination write per beat through an output register.
// ----------------------------------------------------------------------------
module nnfr_back
  import nnfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  nnfr_job_t          pop_job,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] dst_x,
  output logic [COORD_W-1:0] dst_y,
  output logic [PIX_W-1:0]   out_pixel,
  output logic               last
);

  logic             busy;
  nnfr_job_t        job;
  logic [REP_W-1:0] row_off;
  logic [REP_W-1:0] col_off;
  logic             out_free;
  logic             row_end;
  logic             job_end;

  assign out_free = !out_valid || !out_stall;
  assign pop      = !busy && !empty;
  assign row_end  = (col_off == job.cols - 4'd1);
  assign job_end  = row_end && (row_off == job.rows - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= busy;
        if (busy && job_end) begin
          busy <= 1'b0;
        end
      end
      if (pop) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job     <= pop_job;
      row_off <= '0;
      col_off <= '0;
    end else if (busy && out_free) begin
      dst_x     <= job.base_x + COORD_W'(col_off);
      dst_y     <= job.base_y + COORD_W'(row_off);
      out_pixel <= job.pixel;
      last      <= job_end;
      if (row_end) begin
        col_off <= '0;
        row_off <= row_off + 4'd1;
      end else begin
        col_off <= col_off + 4'd1;
      end
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-neighbor forward resize. Source pixels
// go in from a queue with random gaps while the write port is stalled at
// random. A predictor tracks the scan position and settings, builds the
// destination writes for every accepted pixel, and each write beat is
// compared against the oldest write still due.
// ----------------------------------------------------------------------------
module tb;
  import nnfr_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int SETTLE      = 30;
  localparam int RUN_PIXELS  = 210;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pixel;
    logic               last;
  } dst_write_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [RATIO_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] dst_x;
  logic [COORD_W-1:0] dst_y;
  logic [PIX_W-1:0]   out_pixel;
  logic               last;

  logic [DIM_W-1:0]   src_w_cfg = 13'd1;
  logic [DIM_W-1:0]   src_h_cfg = 13'd1;
  logic [DIM_W-1:0]   dst_w_cfg = 13'd1;
  logic [DIM_W-1:0]   dst_h_cfg = 13'd1;
  logic [RATIO_W-1:0] x_ratio_cfg = ONE_Q16;
  logic [RATIO_W-1:0] y_ratio_cfg = ONE_Q16;
  logic [COORD_W-1:0] col_pos = '0;
  logic [COORD_W-1:0] row_pos = '0;

  logic [PIX_W-1:0] pixel_queue[$];
  dst_write_t       writes_due[$];
  int               pixels_queued = 0;
  int               pixels_taken = 0;
  int               mismatch_count = 0;
  bit               in_taken = 1'b0;
  bit               quiet = 1'b0;
  int               in_gap = 0;
  int               stall_left = 0;
  int               stuck_cycles = 0;

  nearest_neighbor_forward_resize_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dst_x        (dst_x),
    .dst_y        (dst_y),
    .out_pixel    (out_pixel),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic int unsigned dim_limit(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
  endfunction

  function automatic int unsigned repeats(input logic [RATIO_W-1:0] ratio);
    int unsigned n;
    if (ratio <= ONE_Q16) return 1;
    n = (ratio >> 16) + 1;
    return (n > MAX_REPEAT) ? int'(MAX_REPEAT) : n;
  endfunction

  function automatic void plan_writes(input logic [PIX_W-1:0] pix);
    int unsigned     dw, dh, sw, sh, rx, ry;
    longint unsigned bx, by, lx, ly;
    int unsigned     next_col, next_row;
    dst_write_t      batch[$];
    dst_write_t      w;
    dw = dim_limit(dst_w_cfg);
    dh = dim_limit(dst_h_cfg);
    sw = dim_limit(src_w_cfg);
    sh = dim_limit(src_h_cfg);
    rx = repeats(x_ratio_cfg);
    ry = repeats(y_ratio_cfg);
    bx = (longint'(col_pos) * longint'(x_ratio_cfg)) >> 16;
    by = (longint'(row_pos) * longint'(y_ratio_cfg)) >> 16;
    for (int i = 0; i < ry; i++) begin
      ly = by + i;
      if (ly >= dh) break;
      for (int j = 0; j < rx; j++) begin
        lx = bx + j;
        if (lx >= dw) break;
        w.x = lx[COORD_W-1:0];
        w.y = ly[COORD_W-1:0];
        w.pixel = pix;
        w.last = 1'b0;
        batch.push_back(w);
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) writes_due.push_back(batch[k]);
    next_col = col_pos + 1;
    next_row = row_pos;
    if (next_col >= sw) begin
      next_col = 0;
      next_row = next_row + 1;
      if (next_row >= sh) next_row = 0;
    end
    col_pos = next_col[COORD_W-1:0];
    row_pos = next_row[COORD_W-1:0];
  endfunction

  // Inputs change on the falling edge; acceptance is recorded on the rising edge.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst || in_gap > 0 || pixel_queue.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_pixel <= pixel_queue.pop_front();
        in_gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_len();
      end
    end
    if (stall_left == 0 && !quiet && $urandom_range(0, 2) == 0) stall_left = pick_len();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    dst_write_t w;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        plan_writes(in_pixel);
        pixels_taken++;
      end
      if (out_valid && !out_stall) begin
        if (writes_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected write beat: x=%0d y=%0d pixel=%h last=%b",
                     dst_x, dst_y, out_pixel, last);
          mismatch_count++;
        end else begin
          w = writes_due.pop_front();
          if (dst_x !== w.x || dst_y !== w.y || out_pixel !== w.pixel || last !== w.last) begin
            if (mismatch_count < 10)
              $display("write mismatch: expected x=%0d y=%0d pixel=%h last=%b, got x=%0d y=%0d pixel=%h last=%b",
                       w.x, w.y, w.pixel, w.last, dst_x, dst_y, out_pixel, last);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [RATIO_W-1:0] size_word(input int unsigned v);
    logic [RATIO_W-1:0] w;
    w = RATIO_W'($urandom);
    if ($urandom_range(0, 2) != 0) w = '0;
    w[DIM_W-1:0] = v[DIM_W-1:0];
    return w;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATIO_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SRC_WIDTH:  src_w_cfg = data[DIM_W-1:0];
      CFG_SRC_HEIGHT: src_h_cfg = data[DIM_W-1:0];
      CFG_DST_WIDTH:  dst_w_cfg = data[DIM_W-1:0];
      CFG_DST_HEIGHT: dst_h_cfg = data[DIM_W-1:0];
      CFG_X_RATIO:    x_ratio_cfg = data;
      CFG_Y_RATIO:    y_ratio_cfg = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned sw, sh, dw, dh,
                            input logic [RATIO_W-1:0] xr, yr);
    write_reg(CFG_SRC_WIDTH, size_word(sw));
    write_reg(CFG_SRC_HEIGHT, size_word(sh));
    write_reg(CFG_DST_WIDTH, size_word(dw));
    write_reg(CFG_DST_HEIGHT, size_word(dh));
    write_reg(CFG_X_RATIO, xr);
    write_reg(CFG_Y_RATIO, yr);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] p);
    pixel_queue.push_back(p);
    pixels_queued++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pixels_taken != pixels_queued || writes_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int unsigned        sw, sh, dw, dh, n, mode, phase;
    logic [RATIO_W-1:0] xr, yr;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settings after reset: every pixel lands on the single destination pixel.
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    drain();

    // Upscale by 2.5 with the right and bottom edges clipped.
    set_config(4, 2, 9, 4, 29'd163840, 29'd163840);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'h5555_5555);
    queue_pixel(32'hAAAA_AAAA);
    queue_pixel(32'h0123_4567);
    queue_pixel(32'h89AB_CDEF);
    queue_pixel(32'h8000_0001);
    queue_pixel(32'h7FFF_FFFE);
    drain();

    // Downscale: several source pixels overwrite the same destination pixel.
    set_config(8, 1, 3, 1, 29'd24576, ONE_Q16);
    for (int i = 0; i < 4; i++) queue_pixel($urandom);
    drain();

    // Zero sizes give no writes; a zero ratio maps everything to column 0.
    set_config(0, 0, 0, 3, ONE_Q16, ONE_Q16);
    queue_pixel($urandom);
    queue_pixel($urandom);
    drain();
    set_config(0, 0, 4, 1, 29'd0, ONE_Q16);
    queue_pixel($urandom);
    drain();

    // Largest ratios and oversized destination: a full 8 by 8 block per pixel.
    set_config(1, 1, 8191, 8191, 29'h1000_0000, 29'h1000_0000);
    queue_pixel($urandom);
    queue_pixel($urandom);
    drain();
    set_config(1, 1, 4096, 4096, 29'h1FFF_FFFF, 29'h1FFF_FFFF);
    queue_pixel($urandom);
    drain();

    // A ratio of exactly 2.0 repeats three times, just above 1.0 twice.
    set_config(2, 2, 4096, 4096, 29'd131072, 29'd65537);
    for (int i = 0; i < 4; i++) queue_pixel($urandom);
    drain();

    phase = 0;
    while (pixels_queued < RUN_PIXELS) begin
      quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      sw = $urandom_range(1, 6);
      sh = $urandom_range(1, 4);
      n = $urandom_range(4, 16);
      if (mode <= 5) begin
        dw = $urandom_range(1, sw * 4);
        dh = $urandom_range(1, sh * 4);
        xr = RATIO_W'((dw << 16) / sw);
        yr = RATIO_W'((dh << 16) / sh);
        n = sw * sh * $urandom_range(1, 2);
        if (n > 40) n = 40;
      end else if (mode == 6) begin
        dw = $urandom_range(1, 8191);
        dh = $urandom_range(1, 8191);
        xr = RATIO_W'($urandom);
        yr = RATIO_W'($urandom_range(0, 4 * 65536));
      end else if (mode == 7) begin
        sw = $urandom_range(0, 2);
        sh = $urandom_range(0, 2);
        dw = $urandom_range(0, 1);
        dh = $urandom_range(0, 3);
        xr = RATIO_W'($urandom_range(0, 2) * 32768);
        yr = RATIO_W'($urandom_range(0, 4) * 32768);
      end else if (mode == 8) begin
        sw = $urandom_range(100, 8191);
        sh = $urandom_range(1, 3);
        dw = 8191;
        dh = $urandom_range(1, 8191);
        xr = RATIO_W'($urandom_range(0, 65536));
        yr = RATIO_W'($urandom_range(0, 3 * 65536));
      end else begin
        sw = $urandom_range(1, 2);
        sh = $urandom_range(1, 2);
        xr = RATIO_W'(($urandom_range(4, 7) << 16) | $urandom_range(0, 65535));
        yr = RATIO_W'(($urandom_range(4, 7) << 16) | $urandom_range(0, 65535));
        dw = $urandom_range(1, 20);
        dh = $urandom_range(1, 20);
      end
      set_config(sw, sh, dw, dh, xr, yr);
      for (int i = 0; i < n / 2; i++) queue_pixel($urandom);
      // The first random phase holds the source back until the port is empty.
      if (phase == 0) drain();
      for (int i = n / 2; i < n; i++) queue_pixel($urandom);
      drain();
      phase++;
    end

    quiet = 1'b0;
    if (writes_due.size() != 0) begin
      $display("%0d writes never arrived", writes_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
